### sv/satadj_pkg.sv
// Shared types, constants and tables for the saturation adjust block.
package satadj_pkg;

  localparam int FRAC_BITS_DEF = 12;
  localparam int NUM_STAGES    = 10;
  localparam int DIV_STAGES    = 4;
  localparam int DIV_BITS      = 4;

  localparam logic [16:0] UNITY_Q16 = 17'd65536;
  localparam logic [15:0] KNEE_Q16  = 16'd39322;
  localparam logic [16:0] FLOOR_Q16 = 17'd13107;

  typedef struct packed {
    logic [15:0] red_in;
    logic [15:0] green_in;
    logic [15:0] blue_in;
  } in_pix_t;

  typedef struct packed {
    logic [15:0] red_out;
    logic [15:0] green_out;
    logic [15:0] blue_out;
  } out_pix_t;

  // Settings derived from the amount register
  typedef struct packed {
    logic        zero;
    logic        pos;
    logic [17:0] factor;
    logic [16:0] delta;
  } cfg_t;

  // Per-pixel sideband that rides along the pipe
  typedef struct packed {
    logic [15:0] r;
    logic [15:0] g;
    logic [15:0] b;
    logic [15:0] y;
    logic        skin;
    logic        yok;
    logic        big;
  } side_t;

  // Protection curve samples, Q16, 1/32 apart above the knee
  function automatic logic [16:0] prot_tab(input logic [3:0] i);
    logic [16:0] v;
    case (i)
      4'd0:    v = 17'd65536;
      4'd1:    v = 17'd56875;
      4'd2:    v = 17'd49314;
      4'd3:    v = 17'd42604;
      4'd4:    v = 17'd36574;
      4'd5:    v = 17'd31097;
      4'd6:    v = 17'd26081;
      4'd7:    v = 17'd21455;
      4'd8:    v = 17'd17161;
      4'd9:    v = 17'd13156;
      4'd10:   v = 17'd9403;
      default: v = 17'd9403;
    endcase
    return v;
  endfunction

endpackage

### sv/saturation_adjust_skin_protect_unit.sv
// Top level of the luma-preserving saturation adjust with skin protection.
// Usage:
//  - Input channel in_valid/in_stall/in_pixel carries one RGB pixel (Q4.12).
//    A transfer happens at a clock edge with in_valid high and in_stall low.
//  - Output channel out_valid/out_stall/out_pixel carries the adjusted pixel,
//    one result per input pixel, in order.
//  - cfg_valid/cfg_data writes the signed saturation amount; cfg_ready is
//    always high. Write only while the pipe is empty; the new setting passes
//    through the amount register and then the settings register to take effect.
//  - Ten register stages (luma, ratio divider at four quotient bits a stage,
//    curve lookup, gain, blend, clamp) lie between the input transfer and
//    out_valid. Throughput is one pixel per clock while out_stall is low.
//  - Each stage holds its own valid bit. A stalled output only backs up
//    stages that hold data, so bubbles fill and nothing is lost or repeated.
//  - Synchronous active-low reset empties the pipe and sets amount to zero
//    (pixels pass unchanged).
module saturation_adjust_skin_protect_unit import satadj_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  in_pix_t    in_pixel,
  output logic       out_valid,
  input  logic       out_stall,
  output out_pix_t   out_pixel,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_data
);

  logic [NUM_STAGES-1:0] v_r, v_nxt;
  logic [NUM_STAGES-1:0] en;
  cfg_t                  cfg;
  side_t                 side_f, side_d, side_g;
  logic [15:0]           chroma_f, q_d;
  logic [16:0]           d_f;
  logic [17:0]           factor_g;

  assign cfg_ready = 1'b1;

  // Stage k loads when it is empty or the stage after it moves on.
  always_comb begin
    en[NUM_STAGES-1] = !v_r[NUM_STAGES-1] || !out_stall;
    for (int k = NUM_STAGES-2; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
    v_nxt[0] = en[0] ? in_valid : v_r[0];
    for (int k = 1; k < NUM_STAGES; k++) begin
      if (en[k]) v_nxt[k] = v_r[k-1];
      else       v_nxt[k] = v_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v_r <= '0;
    else        v_r <= v_nxt;
  end

  assign in_stall  = !en[0];
  assign out_valid = v_r[NUM_STAGES-1];

  satadj_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (cfg_valid && cfg_ready),
    .wr_data (cfg_data),
    .cfg_o   (cfg)
  );

  // stages 0-1: luma, chroma span, skin test
  satadj_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk      (clk),
    .en1      (en[0]),
    .en2      (en[1]),
    .pix_i    (in_pixel),
    .side_o   (side_f),
    .chroma_o (chroma_f),
    .d_o      (d_f)
  );

  // stages 2-5: chroma/luma ratio
  satadj_div u_div (
    .clk      (clk),
    .en       (en[2 +: DIV_STAGES]),
    .side_i   (side_f),
    .chroma_i (chroma_f),
    .d_i      (d_f),
    .side_o   (side_d),
    .q_o      (q_d)
  );

  // stages 6-7: protection value and gain factor
  satadj_gain u_gain (
    .clk      (clk),
    .en1      (en[6]),
    .en2      (en[7]),
    .cfg_i    (cfg),
    .side_i   (side_d),
    .q_i      (q_d),
    .side_o   (side_g),
    .factor_o (factor_g)
  );

  // stages 8-9: blend and output register
  satadj_mix u_mix (
    .clk      (clk),
    .en1      (en[8]),
    .en2      (en[9]),
    .cfg_i    (cfg),
    .side_i   (side_g),
    .factor_i (factor_g),
    .pix_o    (out_pixel)
  );

`ifndef SYNTH
  // Input backs up only when every stage holds a pixel.
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (&v_r))
    else $error("input stalled with a bubble in the pipe");

  // A full pipe facing a stalled output cannot take a pixel.
  a_full_hold: assert property (@(posedge clk) disable iff (!rst_n)
    ((&v_r) && out_stall) |-> in_stall)
    else $error("full pipe accepted a pixel while output stalled");

  // The last divider stage, if it held a pixel and could not move, still holds it.
  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (v_r[5] && !en[5]) |=> v_r[5])
    else $error("pixel lost in the divider");
`endif

endmodule

### sv/satadj_cfg.sv
// Amount register and the gain settings derived from it.
module satadj_cfg import satadj_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       wr_en,
  input  logic [7:0] wr_data,
  output cfg_t       cfg_o
);

  logic signed [7:0] amount_r;
  logic signed [7:0] s_c;
  logic [7:0]        u;
  logic [12:0]       rv;
  logic [25:0]       rq;
  logic [17:0]       factor;
  cfg_t              cfg_r, cfg_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) amount_r <= '0;
    else if (wr_en) amount_r <= wr_data;
  end

  always_comb begin
    if (amount_r < -8'sd100)      s_c = -8'sd100;
    else if (amount_r > 8'sd100)  s_c = 8'sd100;
    else                          s_c = amount_r;
    u      = 8'(s_c + 8'sd100);
    // (65536u + 50) / 100 = 655u + (36u + 50) / 100, small divide by reciprocal
    rv     = 13'(13'd36 * u + 13'd50);
    rq     = 26'(rv * 26'd5243);
    factor = 18'(18'd655 * u) + 18'(rq[25:19]);
    cfg_nxt.zero   = (s_c == 8'sd0);
    cfg_nxt.pos    = (s_c > 8'sd0);
    cfg_nxt.factor = factor;
    cfg_nxt.delta  = 17'(factor - 18'(UNITY_Q16));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.zero   <= 1'b1;
      cfg_r.pos    <= 1'b0;
      cfg_r.factor <= 18'(UNITY_Q16);
      cfg_r.delta  <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg_o = cfg_r;

endmodule

### sv/satadj_front.sv
// Luma, chroma span and skin-tone test, two stages.
module satadj_front import satadj_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        en1,
  input  logic        en2,
  input  in_pix_t     pix_i,
  output side_t       side_o,
  output logic [15:0] chroma_o,
  output logic [16:0] d_o
);

  localparam int          ONE_Q   = 1 << FRAC_BITS;
  localparam int          EPS_RAW = (ONE_Q + 500) / 1000;
  localparam logic [16:0] EPS_Q   = 17'((EPS_RAW != 0) ? EPS_RAW : 1);
  localparam logic [15:0] SKIN_LO = 16'((2 * ONE_Q + 5) / 10);
  localparam logic [15:0] SKIN_HI = 16'((8 * ONE_Q + 5) / 10);

  logic [15:0] r1_r, g1_r, b1_r, chroma1_r;
  logic [29:0] pr_r;
  logic [31:0] pg_r;
  logic [28:0] pb_r;
  logic        sk1_r;
  logic [15:0] mx, mn;
  logic [20:0] ge, be;
  logic        sk1;
  logic [32:0] ysum;
  logic [15:0] y;
  logic [16:0] d;
  side_t       side_r;
  logic [15:0] chroma_r;
  logic [16:0] d_r;

  always_comb begin
    mx = pix_i.red_in;
    mn = pix_i.red_in;
    if (pix_i.green_in > mx) mx = pix_i.green_in;
    if (pix_i.blue_in  > mx) mx = pix_i.blue_in;
    if (pix_i.green_in < mn) mn = pix_i.green_in;
    if (pix_i.blue_in  < mn) mn = pix_i.blue_in;
    ge  = 21'(pix_i.green_in) + 21'(EPS_Q);
    be  = 21'(pix_i.blue_in)  + 21'(EPS_Q);
    sk1 = (pix_i.red_in >= pix_i.green_in) && (pix_i.green_in >= pix_i.blue_in) &&
          (25'd10 * 25'(pix_i.red_in)   > 25'd11 * 25'(ge)) &&
          (25'd5  * 25'(pix_i.red_in)   < 25'd8  * 25'(ge)) &&
          (25'd10 * 25'(pix_i.green_in) > 25'd11 * 25'(be)) &&
          (25'd2  * 25'(pix_i.green_in) < 25'd3  * 25'(be));
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      r1_r      <= pix_i.red_in;
      g1_r      <= pix_i.green_in;
      b1_r      <= pix_i.blue_in;
      pr_r      <= 30'(30'd13933 * 30'(pix_i.red_in));
      pg_r      <= 32'(32'd46871 * 32'(pix_i.green_in));
      pb_r      <= 29'(29'd4732  * 29'(pix_i.blue_in));
      chroma1_r <= 16'(mx - mn);
      sk1_r     <= sk1;
    end
  end

  always_comb begin
    ysum = 33'(pr_r) + 33'(pg_r) + 33'(pb_r) + 33'd32768;
    y    = ysum[31:16];
    d    = 17'(y) + EPS_Q;
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      side_r.r    <= r1_r;
      side_r.g    <= g1_r;
      side_r.b    <= b1_r;
      side_r.y    <= y;
      side_r.skin <= sk1_r && (y >= SKIN_LO) && (y <= SKIN_HI);
      side_r.yok  <= (17'(y) >= EPS_Q);
      side_r.big  <= (17'(chroma1_r) >= d);
      chroma_r    <= chroma1_r;
      d_r         <= d;
    end
  end

  assign side_o   = side_r;
  assign chroma_o = chroma_r;
  assign d_o      = d_r;

endmodule

### sv/satadj_div.sv
// Pipelined restoring divider for the chroma-to-luma ratio, four quotient bits a stage.
module satadj_div import satadj_pkg::*; (
  input  logic                  clk,
  input  logic [DIV_STAGES-1:0] en,
  input  side_t                 side_i,
  input  logic [15:0]           chroma_i,
  input  logic [16:0]           d_i,
  output side_t                 side_o,
  output logic [15:0]           q_o
);

  side_t       side_r [DIV_STAGES];
  logic [16:0] rem_r  [DIV_STAGES];
  logic [16:0] d_r    [DIV_STAGES];
  logic [15:0] q_r    [DIV_STAGES];

  logic [16:0] rem_in [DIV_STAGES];
  logic [15:0] q_in   [DIV_STAGES];
  logic [16:0] rem_nx [DIV_STAGES];
  logic [15:0] q_nx   [DIV_STAGES];
  logic [16:0] d_in   [DIV_STAGES];
  side_t       side_in[DIV_STAGES];

  always_comb begin
    logic [17:0] t;
    for (int k = 0; k < DIV_STAGES; k++) begin
      if (k == 0) begin
        // ratio at or above one is flagged separately; start from zero then
        rem_in[k]  = side_i.big ? 17'd0 : 17'(chroma_i);
        q_in[k]    = '0;
        d_in[k]    = d_i;
        side_in[k] = side_i;
      end else begin
        rem_in[k]  = rem_r[k-1];
        q_in[k]    = q_r[k-1];
        d_in[k]    = d_r[k-1];
        side_in[k] = side_r[k-1];
      end
      rem_nx[k] = rem_in[k];
      q_nx[k]   = q_in[k];
      for (int j = 0; j < DIV_BITS; j++) begin
        t = {rem_nx[k], 1'b0};
        if (t >= 18'(d_in[k])) begin
          rem_nx[k] = 17'(t - 18'(d_in[k]));
          q_nx[k]   = {q_nx[k][14:0], 1'b1};
        end else begin
          rem_nx[k] = t[16:0];
          q_nx[k]   = {q_nx[k][14:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < DIV_STAGES; k++) begin
      if (en[k]) begin
        rem_r[k]  <= rem_nx[k];
        q_r[k]    <= q_nx[k];
        d_r[k]    <= d_in[k];
        side_r[k] <= side_in[k];
      end
    end
  end

  assign side_o = side_r[DIV_STAGES-1];
  assign q_o    = q_r[DIV_STAGES-1];

endmodule

### sv/satadj_gain.sv
// Protection curve lookup and final gain factor, two stages.
module satadj_gain import satadj_pkg::*; (
  input  logic        clk,
  input  logic        en1,
  input  logic        en2,
  input  cfg_t        cfg_i,
  input  side_t       side_i,
  input  logic [15:0] q_i,
  output side_t       side_o,
  output logic [17:0] factor_o
);

  logic [15:0] t;
  logic [3:0]  idx;
  logic [16:0] ta, tb, p;
  logic [24:0] slope;
  logic [16:0] delta_s;
  side_t       side1_r, side2_r;
  logic [16:0] p_r, delta_r;
  logic        prot_r;
  logic [33:0] dp;
  logic [16:0] delta2;
  logic [17:0] factor_r;

  always_comb begin
    t     = q_i - KNEE_Q16;
    idx   = t[14:11];
    ta    = prot_tab(idx);
    tb    = prot_tab(4'(idx + 4'd1));
    slope = 25'(14'(ta - tb) * t[10:0]);
    if (side_i.big || idx >= 4'd10) p = FLOOR_Q16;
    else                            p = ta - 17'(slope[24:11]);
    if (p < FLOOR_Q16) p = FLOOR_Q16;
    delta_s = side_i.skin ? 17'((18'(cfg_i.delta) + 18'd1) >> 1) : cfg_i.delta;
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      side1_r <= side_i;
      p_r     <= p;
      delta_r <= delta_s;
      prot_r  <= side_i.yok && (side_i.big || q_i > KNEE_Q16);
    end
  end

  always_comb begin
    dp     = 34'(delta_r * p_r) + 34'd32768;
    delta2 = prot_r ? dp[32:16] : delta_r;
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      side2_r  <= side1_r;
      factor_r <= cfg_i.pos ? 18'(UNITY_Q16) + 18'(delta2) : cfg_i.factor;
    end
  end

  assign side_o   = side2_r;
  assign factor_o = factor_r;

endmodule

### sv/satadj_mix.sv
// Channel blend toward luma with floor and top saturation, two stages.
module satadj_mix import satadj_pkg::*; (
  input  logic        clk,
  input  logic        en1,
  input  logic        en2,
  input  cfg_t        cfg_i,
  input  side_t       side_i,
  input  logic [17:0] factor_i,
  output out_pix_t    pix_o
);

  logic signed [35:0] pr_r, pg_r, pb_r;
  logic [15:0]        y_r;
  side_t              side_r;
  out_pix_t           pix_r;

  function automatic logic signed [35:0] blend_mul(input logic [15:0] c,
                                                    input logic [15:0] y,
                                                    input logic [17:0] f);
    logic signed [16:0] diff;
    logic signed [18:0] fs;
    diff = $signed({1'b0, c}) - $signed({1'b0, y});
    fs   = $signed({1'b0, f});
    return 36'(diff * fs);
  endfunction

  function automatic logic [15:0] finish(input logic signed [35:0] prod,
                                         input logic [15:0] y);
    logic signed [37:0] w;
    w = $signed({6'd0, y, 16'd0}) + 38'(prod) + 38'sd32768;
    if (w < 0)                 return 16'd0;
    else if (w[37:32] != 6'd0) return 16'hFFFF;
    else                       return w[31:16];
  endfunction

  always_ff @(posedge clk) begin
    if (en1) begin
      pr_r   <= blend_mul(side_i.r, side_i.y, factor_i);
      pg_r   <= blend_mul(side_i.g, side_i.y, factor_i);
      pb_r   <= blend_mul(side_i.b, side_i.y, factor_i);
      y_r    <= side_i.y;
      side_r <= side_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      if (cfg_i.zero) begin
        pix_r.red_out   <= side_r.r;
        pix_r.green_out <= side_r.g;
        pix_r.blue_out  <= side_r.b;
      end else begin
        pix_r.red_out   <= finish(pr_r, y_r);
        pix_r.green_out <= finish(pg_r, y_r);
        pix_r.blue_out  <= finish(pb_r, y_r);
      end
    end
  end

  assign pix_o = pix_r;

endmodule

### bench/testbench.sv
// Self-checking testbench for the saturation adjust unit with skin protection.
module testbench import satadj_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int EPS_Q    = 4;     // 0.001 in Q4.12, rounded
  localparam int SKIN_LO  = 819;   // 0.2 in Q4.12
  localparam int SKIN_HI  = 3277;  // 0.8 in Q4.12
  localparam int LATENCY  = 10;
  localparam int HOLD_LEN = 60;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  in_pix_t    in_pixel = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  out_pix_t   out_pixel;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [7:0] cfg_data = '0;

  // model copy of the amount register
  logic signed [7:0] amount_q = '0;

  out_pix_t   pending_pix[$];
  int         err_cnt = 0;
  int         send_idle_pct = 0;
  int         recv_idle_pct = 0;
  int         hold_req = 0;      // bumped to ask for a long receiver hold-off
  int         hold_seen = 0;
  int         hold_cycles = 0;   // long receiver hold-off, counted below

  saturation_adjust_skin_protect_unit u_dut (
    .clk, .rst_n, .in_valid, .in_stall, .in_pixel,
    .out_valid, .out_stall, .out_pixel, .cfg_valid, .cfg_ready, .cfg_data
  );

  always #5 clk = ~clk;

  // Protection gain from the table curve for a ratio above the knee, Q16.
  function automatic longint unsigned prot_gain(longint unsigned x);
    longint unsigned t, i, a, b, p;
    t = x - KNEE_Q16;
    i = t >> 11;
    if (i >= 10) begin
      p = FLOOR_Q16;
    end else begin
      a = prot_tab(4'(i));
      b = prot_tab(4'(i + 1));
      p = a - (((a - b) * (t & 2047)) >> 11);
    end
    return (p < FLOOR_Q16) ? FLOOR_Q16 : p;
  endfunction

  function automatic bit is_skin(longint r, longint g, longint b, longint y);
    if (r < g || g < b) return 1'b0;
    if (y < SKIN_LO || y > SKIN_HI) return 1'b0;
    return (10 * r > 11 * (g + EPS_Q)) && (5 * r < 8 * (g + EPS_Q)) &&
           (10 * g > 11 * (b + EPS_Q)) && (2 * g < 3 * (b + EPS_Q));
  endfunction

  function automatic logic [15:0] blend(longint c, longint y, longint f);
    longint v;
    v = y * 65536 + (c - y) * f;
    if (v < 0) return 16'd0;
    v = (v + 32768) >>> 16;
    return (v > 65535) ? 16'hFFFF : 16'(v);
  endfunction

  // Expected adjusted pixel for the current amount
  function automatic out_pix_t adjust_pixel(in_pix_t p);
    out_pix_t o;
    longint r, g, b, y, s, f, d, mx, mn;
    longint unsigned x;
    r = p.red_in; g = p.green_in; b = p.blue_in;
    s = amount_q;
    if (s < -100) s = -100;
    if (s > 100) s = 100;
    if (s == 0) begin
      o.red_out = p.red_in; o.green_out = p.green_in; o.blue_out = p.blue_in;
      return o;
    end
    y = (13933 * r + 46871 * g + 4732 * b + 32768) >> 16;
    f = (65536 * (100 + s) + 50) / 100;
    if (s > 0) begin
      d = f - 65536;
      if (is_skin(r, g, b, y)) d = (d + 1) >> 1;
      if (y >= EPS_Q) begin
        mx = r; mn = r;
        if (g > mx) mx = g;
        if (b > mx) mx = b;
        if (g < mn) mn = g;
        if (b < mn) mn = b;
        x = ((mx - mn) << 16) / (y + EPS_Q);
        if (x > KNEE_Q16) d = (d * longint'(prot_gain(x)) + 32768) >> 16;
      end
      f = 65536 + d;
    end
    o.red_out = blend(r, y, f);
    o.green_out = blend(g, y, f);
    o.blue_out = blend(b, y, f);
    return o;
  endfunction

  // Offer one pixel; predict at the transfer edge. in_valid stays high so
  // that the next pixel can follow back to back; idling or draining drops it.
  task automatic send_pixel(in_pix_t p);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_pixel <= p;
    do @(posedge clk); while (in_stall);
    pending_pix.push_back(adjust_pixel(p));
  endtask

  task automatic send_rgb(int r, int g, int b);
    in_pix_t p;
    p.red_in = 16'(r); p.green_in = 16'(g); p.blue_in = 16'(b);
    send_pixel(p);
  endtask

  task automatic drain_pipe();
    in_valid <= 1'b0;
    while (pending_pix.size() != 0) @(posedge clk);
    repeat (LATENCY + 2) @(posedge clk);
  endtask

  task automatic write_amount(logic [7:0] v);
    drain_pipe();
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    amount_q = v;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Random pixel: mixes skin-like, nominal-range, dark and full-range pixels.
  task automatic send_random_pixel();
    int r, g, b;
    case ($urandom_range(3))
      0: begin
        g = $urandom_range(800, 3000);
        r = g * $urandom_range(111, 158) / 100;
        b = g * 100 / $urandom_range(112, 149);
      end
      1: begin
        r = $urandom_range(4096); g = $urandom_range(4096); b = $urandom_range(4096);
      end
      2: begin
        r = $urandom_range(8); g = $urandom_range(8); b = $urandom_range(8);
      end
      default: begin
        r = $urandom_range(65535); g = $urandom_range(65535); b = $urandom_range(65535);
      end
    endcase
    send_rgb(r, g, b);
  endtask

  task automatic test_passthrough();
    send_rgb(0, 0, 0);
    send_rgb(65535, 65535, 65535);
    send_rgb(65535, 0, 12345);
  endtask

  task automatic test_directed();
    logic [7:0] amts[6] = '{8'sd100, -8'sd100, 8'sd127, -8'sd128, 8'sd50, -8'sd30};
    foreach (amts[k]) begin
      write_amount(amts[k]);
      send_rgb(0, 0, 0);
      send_rgb(65535, 65535, 65535);
      send_rgb(65535, 0, 0);          // overflow at top
      send_rgb(2600, 2000, 1600);     // skin tone
      send_rgb(3, 1, 0);              // very dark
      send_rgb(4096, 1000, 200);      // strongly saturated
      send_rgb(0, 65535, 0);
    end
  endtask

  task automatic test_random(int n);
    logic [7:0] a;
    for (int k = 0; k < n; k++) begin
      if (k % 100 == 0) begin
        a = (k % 300 == 0) ? 8'($urandom_range(255)) : 8'($signed($urandom_range(200)) - 100);
        write_amount(a);
      end
      send_random_pixel();
    end
  endtask

  // Long receiver hold-off while the sender keeps offering pixels
  task automatic test_backpressure();
    hold_req++;
    repeat (40) send_random_pixel();
  endtask

  // Receiver stall generator
  always @(posedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_cycles <= HOLD_LEN;
      out_stall <= 1'b1;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Result checker
  always @(posedge clk) begin
    out_pix_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_pix.size() == 0) begin
        $display("%0t: unexpected pixel %h", $realtime, out_pixel);
        err_cnt++;
      end else begin
        e = pending_pix.pop_front();
        if (e.red_out !== out_pixel.red_out)
          $display("%0t: red exp %0d got %0d", $realtime, e.red_out, out_pixel.red_out);
        if (e.green_out !== out_pixel.green_out)
          $display("%0t: green exp %0d got %0d", $realtime, e.green_out, out_pixel.green_out);
        if (e.blue_out !== out_pixel.blue_out)
          $display("%0t: blue exp %0d got %0d", $realtime, e.blue_out, out_pixel.blue_out);
        if (e !== out_pixel) err_cnt++;
      end
    end
  end

  initial begin
    #5ms;
    $display("testbench: FAIL");
    $finish;
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_passthrough();
    test_directed();
    send_idle_pct = 19; recv_idle_pct = 76;
    test_random(300);
    test_backpressure();
    send_idle_pct = 76; recv_idle_pct = 19;
    test_random(300);
    send_idle_pct = 0; recv_idle_pct = 0;
    test_random(250);
    write_amount(8'd0);
    drain_pipe();
    if (err_cnt == 0 && pending_pix.size() == 0)
      $display("testbench: PASS");
    else
      $display("testbench: FAIL");
    $finish;
  end
endmodule
